>>> rtl/triggered_waveform_player_amp_step_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triggered waveform player
// Clocked assertion wrappers used by the player RTL file.
// ----------------------------------------------------------------------------
`ifndef TRIGGERED_WAVEFORM_PLAYER_AMP_STEP_MACROS_SVH
`define TRIGGERED_WAVEFORM_PLAYER_AMP_STEP_MACROS_SVH

// checked on every rising edge outside reset
`define TWP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// same, written as an implication
`define TWP_ASSERT_IMP(label, pre, post, msg) \
    `TWP_ASSERT(label, (pre) |-> (post), msg)

`endif

>>> rtl/twp_pkg.sv
// ----------------------------------------------------------------------------
// twp_pkg
// Shared constants, register codes and fixed-point helpers of the player.
// ----------------------------------------------------------------------------
package twp_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 18;

    typedef logic [CFG_AW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_WAVE_LENGTH  = 3'd0;
    localparam t_cfg_idx CFG_START_AMP    = 3'd1;
    localparam t_cfg_idx CFG_DELTA_AMP    = 3'd2;
    localparam t_cfg_idx CFG_AMP_COUNT    = 3'd3;
    localparam t_cfg_idx CFG_REPEAT_COUNT = 3'd4;

    typedef logic signed [17:0] t_amp;
    typedef logic signed [15:0] t_q15;
    typedef logic signed [33:0] t_prod;
    typedef logic signed [35:0] t_amp_acc;

    localparam t_q15 TRIG_HALF      = 16'sd8192;
    localparam t_amp AMP_RESET      = 18'sd16384;
    localparam t_amp_acc ACC_MAX    = 36'sd131071;
    localparam t_amp_acc ACC_MIN    = -36'sd131072;

    function automatic t_amp sat_amp(input t_amp_acc a);
        t_amp r;
        if (a > ACC_MAX) begin
            r = 18'sd131071;
        end else if (a < ACC_MIN) begin
            r = -18'sd131072;
        end else begin
            r = a[17:0];
        end
        return r;
    endfunction

    // floor shift by 14, saturate to Q1.15
    function automatic t_q15 sat_q15(input t_prod p);
        logic signed [19:0] q;
        t_q15 r;
        q = p[33:14];
        if (q > 20'sd32767) begin
            r = 16'sd32767;
        end else if (q < -20'sd32768) begin
            r = -16'sd32768;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/triggered_waveform_player_amp_step.sv
// ----------------------------------------------------------------------------
// triggered_waveform_player_amp_step
// Triggered complex waveform player with stepped, saturating amplitude.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// s_axis   in   tuser: mode; tdata: trigger_sample, load_addr, load_re, load_im
// m_axis   out  tuser: playing; tdata: out_re, out_im
// cfg      in   write enable, register index, write data
//
// One word per cycle sustained while the output takes results; a sample tick's
// result goes through the RAM read, the multiply and the saturate into the output
// register. Rate is one RAM read per tick; loads use the write port.
// Reset is synchronous, active low; no clearing pass over the RAM.
// Pipeline stages advance independently, so bubbles collapse under stall.
// ----------------------------------------------------------------------------
`include "triggered_waveform_player_amp_step_macros.svh"

module triggered_waveform_player_amp_step
    import twp_pkg::*;
#(
    parameter int WAVE_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [15:0] trigger_sample, [27:16] load_addr, [43:28] load_re,
    // [59:44] load_im, [63:60] zero
    input  logic [63:0]       i_s_axis_tdata,
    // [0] mode
    input  logic              i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [15:0] out_re, [31:16] out_im
    output logic [31:0]       o_m_axis_tdata,
    // [0] playing
    output logic              o_m_axis_tuser,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata
);

    localparam int AW = $clog2(WAVE_DEPTH);
    localparam int IW = $clog2(WAVE_DEPTH + 1);

    // config
    logic [12:0] r_wave_length;
    t_amp        r_start_amp;
    t_amp        r_delta_amp;
    logic [15:0] r_amp_count;
    logic [15:0] r_repeat_count;

    // play state
    logic [IW-1:0] r_pidx;
    logic          r_idle;
    logic          r_prev;
    logic [15:0]   r_amp_idx;
    logic [15:0]   r_rep_idx;
    t_amp_acc      r_acc;

    // pipeline
    logic        r_s1_v, r_s1_play;
    t_amp        r_s1_amp;
    logic [31:0] r_rdata;
    logic        r_s2_v, r_s2_play;
    t_prod       r_prod_re, r_prod_im;
    logic        r_out_v, r_out_play;
    logic [31:0] r_out_data;

    logic [31:0] wave_mem [WAVE_DEPTH];

    logic out_adv, s2_adv, s1_adv;
    logic in_acc, tick_acc, load_acc;
    logic cfg_valid, restart;

    logic [IW-1:0] len;
    logic          trig_high, trig_edge, idle_t, play;
    logic [IW-1:0] pidx_t, pidx_inc;
    logic          pass_end;
    logic [15:0]   rc_eff, ac_eff;
    logic [16:0]   rep_inc, amp_inc;
    logic          rep_wrap, amp_wrap;
    logic [11:0]   load_addr;
    logic          load_in_range;
    t_amp          amp_value;
    t_amp          n_start_amp;

    assign out_adv  = !r_out_v || i_m_axis_tready;
    assign s2_adv   = !r_s2_v || out_adv;
    assign s1_adv   = !r_s1_v || s2_adv;

    assign o_s_axis_tready = s1_adv;
    assign in_acc   = i_s_axis_tvalid && s1_adv;
    assign tick_acc = in_acc && !i_s_axis_tuser;
    assign load_acc = in_acc && i_s_axis_tuser;

    assign cfg_valid = i_cfg_we && (32'(i_cfg_addr) <= 32'(CFG_REPEAT_COUNT));
    assign restart   = cfg_valid || load_acc;

    assign len = (32'(r_wave_length) > 32'(WAVE_DEPTH)) ? IW'(WAVE_DEPTH)
                                                        : IW'(32'(r_wave_length));

    assign trig_high = $signed(i_s_axis_tdata[15:0]) > TRIG_HALF;
    assign trig_edge = !r_prev && trig_high;
    assign idle_t    = trig_edge ? 1'b0 : r_idle;
    assign pidx_t    = trig_edge ? '0 : r_pidx;
    assign play      = !idle_t && (pidx_t < len);
    assign pidx_inc  = pidx_t + IW'(1);
    assign pass_end  = play && (pidx_inc == len);

    assign rc_eff   = (r_repeat_count == 16'd0) ? 16'd1 : r_repeat_count;
    assign ac_eff   = (r_amp_count == 16'd0) ? 16'd1 : r_amp_count;
    assign rep_inc  = {1'b0, r_rep_idx} + 17'd1;
    assign amp_inc  = {1'b0, r_amp_idx} + 17'd1;
    assign rep_wrap = rep_inc >= {1'b0, rc_eff};
    assign amp_wrap = amp_inc >= {1'b0, ac_eff};

    assign amp_value = sat_amp(r_acc);

    assign load_addr     = i_s_axis_tdata[27:16];
    assign load_in_range = 32'(load_addr) < 32'(WAVE_DEPTH);

    assign n_start_amp = (i_cfg_we && i_cfg_addr == CFG_START_AMP) ? t_amp'(i_cfg_wdata)
                                                                  : r_start_amp;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_length  <= '0;
            r_start_amp    <= AMP_RESET;
            r_delta_amp    <= '0;
            r_amp_count    <= 16'd1;
            r_repeat_count <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WAVE_LENGTH:  r_wave_length  <= i_cfg_wdata[12:0];
                CFG_START_AMP:    r_start_amp    <= t_amp'(i_cfg_wdata);
                CFG_DELTA_AMP:    r_delta_amp    <= t_amp'(i_cfg_wdata);
                CFG_AMP_COUNT:    r_amp_count    <= i_cfg_wdata[15:0];
                CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // play state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pidx    <= '0;
            r_idle    <= 1'b1;
            r_prev    <= 1'b0;
            r_amp_idx <= '0;
            r_rep_idx <= '0;
            r_acc     <= t_amp_acc'(AMP_RESET);
        end else if (restart) begin
            r_idle    <= 1'b1;
            r_prev    <= 1'b0;
            r_amp_idx <= '0;
            r_rep_idx <= '0;
            r_acc     <= t_amp_acc'(n_start_amp);
        end else if (tick_acc) begin
            r_prev <= trig_high;
            r_idle <= idle_t;
            r_pidx <= play ? pidx_inc : pidx_t;
            if (pass_end) begin
                r_rep_idx <= rep_wrap ? 16'd0 : rep_inc[15:0];
                if (rep_wrap) begin
                    r_amp_idx <= amp_wrap ? 16'd0 : amp_inc[15:0];
                    r_acc     <= amp_wrap ? t_amp_acc'(r_start_amp)
                                          : r_acc + t_amp_acc'(r_delta_amp);
                end
            end
        end
    end

    // waveform RAM: one write port for loads, one registered read per tick
    always_ff @(posedge i_clk) begin
        if (load_acc && load_in_range) begin
            wave_mem[AW'(32'(load_addr))] <= i_s_axis_tdata[59:28];
        end
        if (s1_adv) begin
            r_rdata <= wave_mem[pidx_t[AW-1:0]];
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_v <= tick_acc;
            end
            if (s2_adv) begin
                r_s2_v <= r_s1_v;
            end
            if (out_adv) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s1_play <= play;
            r_s1_amp  <= amp_value;
        end
        if (s2_adv) begin
            r_s2_play <= r_s1_play;
            r_prod_re <= r_s1_amp * $signed(r_rdata[15:0]);
            r_prod_im <= r_s1_amp * $signed(r_rdata[31:16]);
        end
        if (out_adv) begin
            r_out_play <= r_s2_play;
            r_out_data <= r_s2_play ? {sat_q15(r_prod_im), sat_q15(r_prod_re)} : 32'd0;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_play;

    `TWP_ASSERT_IMP(a_idle_zero, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata == 32'd0,
                    "idle sample is not zero")
    `TWP_ASSERT_IMP(a_cfg_restart, cfg_valid, ##1 (r_idle && r_rep_idx == 16'd0),
                    "config write did not restart playback")
    `TWP_ASSERT(a_rep_range, r_rep_idx < rc_eff, "repeat index out of range")

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triggered waveform player: loads waveform
// entries, plays triggered passes under several register settings and idle
// patterns, and checks every output sample against a local predictor.
// ----------------------------------------------------------------------------
module testbench;
    import twp_pkg::*;

    localparam int WAVE_DEPTH  = 32;
    localparam int CYCLE_LIMIT = 60000;
    localparam int RX_HOLD_LEN = 400;
    localparam int DRAIN_WAIT  = 12;
    localparam int BURST_WORDS = 85;

    // indexes with no register behind them
    localparam t_cfg_idx CFG_SPARE_LO = 3'd5;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic        mode;
        logic [15:0] trig;
        logic [11:0] addr;
        logic [15:0] re;
        logic [15:0] im;
    } t_stream_word;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        playing;
    } t_sample;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    // [15:0] trigger_sample, [27:16] load_addr, [43:28] load_re,
    // [59:44] load_im, [63:60] zero
    logic [63:0]       i_s_axis_tdata = '0;
    // [0] mode
    logic              i_s_axis_tuser = 1'b0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    // [15:0] out_re, [31:16] out_im
    logic [31:0]       o_m_axis_tdata;
    // [0] playing
    logic              o_m_axis_tuser;
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = '0;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;

    triggered_waveform_player_amp_step #(
        .WAVE_DEPTH(WAVE_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // stimulus and bookkeeping
    t_stream_word tx_pend[$];
    t_stream_word tx_cur;
    t_sample      want_samples[$];
    bit           gen_written[WAVE_DEPTH];
    int unsigned  tx_idle_pct = 0;
    int unsigned  rx_stall_pct = 0;
    bit           rx_hold_go = 1'b0;
    bit           rx_hold_done = 1'b0;
    int unsigned  rx_hold_cnt = 0;
    int unsigned  cycles = 0;
    int unsigned  n_err = 0;
    int unsigned  n_in = 0;
    int unsigned  n_checked = 0;
    int unsigned  n_playing = 0;

    // player state as the predictor sees it
    logic [31:0]  wave_ram[WAVE_DEPTH];
    int unsigned  play_pos = 0;
    bit           player_idle = 1'b1;
    int unsigned  amp_step = 0;
    int unsigned  pass_cnt = 0;
    t_amp         cur_amp = AMP_RESET;
    bit           trig_was_high = 1'b0;
    logic [12:0]  reg_len = '0;
    t_amp         reg_start = AMP_RESET;
    t_amp         reg_delta = '0;
    logic [15:0]  reg_amp_cnt = 16'd1;
    logic [15:0]  reg_rep_cnt = 16'd1;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    function automatic t_amp stepped_amp();
        longint a;
        a = longint'(reg_start) + longint'(amp_step) * longint'(reg_delta);
        if (a > 131071) a = 131071;
        if (a < -131072) a = -131072;
        return t_amp'(a);
    endfunction

    // amplitude times entry, floor shift by 14, clamp to Q1.15
    function automatic logic [15:0] scaled(input logic signed [15:0] d);
        longint p;
        p = (longint'(cur_amp) * longint'(d)) >>> 14;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[15:0];
    endfunction

    task automatic restart_player();
        player_idle   = 1'b1;
        amp_step      = 0;
        pass_cnt      = 0;
        trig_was_high = 1'b0;
        cur_amp       = stepped_amp();
    endtask

    task automatic apply_word(input t_stream_word w);
        int unsigned eff_len;
        int unsigned rc;
        int unsigned ac;
        bit          hi;
        logic [31:0] e;
        t_sample     s;
        if (w.mode) begin
            if (w.addr < WAVE_DEPTH) wave_ram[w.addr] = {w.im, w.re};
            restart_player();
        end else begin
            eff_len = (reg_len > WAVE_DEPTH) ? WAVE_DEPTH : reg_len;
            hi = $signed(w.trig) > TRIG_HALF;
            if (!trig_was_high && hi) begin
                play_pos    = 0;
                player_idle = 1'b0;
            end
            trig_was_high = hi;
            if (player_idle || play_pos >= eff_len) begin
                s = '0;
            end else begin
                e = wave_ram[play_pos];
                s.re = scaled(e[15:0]);
                s.im = scaled(e[31:16]);
                s.playing = 1'b1;
                play_pos++;
                if (play_pos == eff_len) begin
                    rc = (reg_rep_cnt == 0) ? 1 : reg_rep_cnt;
                    ac = (reg_amp_cnt == 0) ? 1 : reg_amp_cnt;
                    pass_cnt = (pass_cnt + 1) % rc;
                    if (pass_cnt == 0) amp_step = (amp_step + 1) % ac;
                    cur_amp = stepped_amp();
                end
            end
            want_samples.push_back(s);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) begin
                apply_word(tx_cur);
                n_in++;
            end
            if (tx_pend.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                tx_cur = tx_pend.pop_front();
                i_s_axis_tdata  <= {4'd0, tx_cur.im, tx_cur.re, tx_cur.addr, tx_cur.trig};
                i_s_axis_tuser  <= tx_cur.mode;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_sample();
        t_sample w;
        if (want_samples.size() == 0) begin
            $error("unexpected sample: out_re %0d out_im %0d playing %0b",
                   $signed(o_m_axis_tdata[15:0]), $signed(o_m_axis_tdata[31:16]),
                   o_m_axis_tuser);
            n_err++;
        end else begin
            w = want_samples.pop_front();
            n_checked++;
            n_playing += w.playing;
            if (o_m_axis_tdata[15:0] !== w.re) begin
                $error("out_re: expected %0d, got %0d", $signed(w.re),
                       $signed(o_m_axis_tdata[15:0]));
                n_err++;
            end
            if (o_m_axis_tdata[31:16] !== w.im) begin
                $error("out_im: expected %0d, got %0d", $signed(w.im),
                       $signed(o_m_axis_tdata[31:16]));
                n_err++;
            end
            if (o_m_axis_tuser !== w.playing) begin
                $error("playing: expected %0b, got %0b", w.playing, o_m_axis_tuser);
                n_err++;
            end
        end
    endtask

    // long receiver hold-off, counted on its own
    always @(posedge i_clk) begin
        if (i_rst_n && rx_hold_go && !rx_hold_done) begin
            rx_hold_cnt  <= rx_hold_cnt + 1;
            rx_hold_done <= (rx_hold_cnt + 1 >= RX_HOLD_LEN);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_sample();
            if (rx_hold_go && !rx_hold_done) begin
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic int low_trig();
        return int'($urandom_range(40960)) - 32768;
    endfunction

    function automatic int high_trig();
        return 8193 + int'($urandom_range(24574));
    endfunction

    task automatic push_tick(input int trig);
        t_stream_word w;
        w.mode = 1'b0;
        w.trig = trig[15:0];
        w.addr = 12'($urandom);
        w.re   = 16'($urandom);
        w.im   = 16'($urandom);
        tx_pend.push_back(w);
    endtask

    task automatic push_load(input int addr, input int re, input int im);
        t_stream_word w;
        w.mode = 1'b1;
        w.trig = 16'($urandom);
        w.addr = addr[11:0];
        w.re   = re[15:0];
        w.im   = im[15:0];
        if (addr < WAVE_DEPTH) gen_written[addr] = 1'b1;
        tx_pend.push_back(w);
    endtask

    task automatic drain();
        while (tx_pend.size() != 0 || i_s_axis_tvalid || want_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input int val);
        bit known;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[CFG_DW-1:0];
        known = 1'b1;
        case (idx)
            CFG_WAVE_LENGTH:  reg_len     = val[12:0];
            CFG_START_AMP:    reg_start   = val[17:0];
            CFG_DELTA_AMP:    reg_delta   = val[17:0];
            CFG_AMP_COUNT:    reg_amp_cnt = val[15:0];
            CFG_REPEAT_COUNT: reg_rep_cnt = val[15:0];
            default:          known = 1'b0;
        endcase
        if (known) restart_player();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // load any entry not yet written that a pass of this length would read, then program
    task automatic set_player(input int len, input int start, input int delta,
                              input int ac, input int rc);
        int lim;
        lim = (len > WAVE_DEPTH) ? WAVE_DEPTH : len;
        for (int a = 0; a < lim; a++)
            if (!gen_written[a]) push_load(a, int'($urandom), int'($urandom));
        drain();
        cfg_write(CFG_WAVE_LENGTH, len);
        cfg_write(CFG_START_AMP, start);
        cfg_write(CFG_DELTA_AMP, delta);
        cfg_write(CFG_AMP_COUNT, ac);
        cfg_write(CFG_REPEAT_COUNT, rc);
    endtask

    // low ticks, a rising edge, then enough ticks for a pass or a cut-short one
    task automatic play_burst(input int len, inout int made);
        int k;
        int m;
        k = $urandom_range(3, 1);
        m = ($urandom_range(3) == 0) ? $urandom_range(len) : len + $urandom_range(3);
        repeat (k) push_tick(low_trig());
        push_tick(high_trig());
        repeat (m) push_tick(($urandom_range(9) == 0) ? low_trig() : high_trig());
        made += k + 1 + m;
    endtask

    task automatic gen_traffic(input int len, input int n);
        int made;
        int r;
        made = 0;
        while (made < n) begin
            r = $urandom_range(99);
            if (r < 7) begin
                push_load($urandom_range(WAVE_DEPTH - 1), int'($urandom), int'($urandom));
                made++;
            end else if (r < 14) begin
                push_tick(int'($urandom));
                made++;
            end else begin
                play_burst(len, made);
            end
        end
    endtask

    function automatic int rand_amp();
        return int'($urandom_range(262143)) - 131072;
    endfunction

    initial begin
        int len;
        int dummy;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero length: edges tracked, output stays zero
        push_tick(8193);
        push_tick(-32768);
        push_tick(32767);
        push_load(0, -32768, 32767);
        push_load(1, 32767, -32768);
        push_load(2, 0, 0);
        push_load(3, 1, -1);
        push_load(WAVE_DEPTH - 1, 32767, 32767);
        // address past the depth: dropped, counters still restart
        push_load(WAVE_DEPTH + 3, 1234, -1234);
        drain();
        cfg_write(CFG_WAVE_LENGTH, 4);
        push_tick(8192);
        repeat (4) push_tick(8193);
        push_tick(8193);
        push_tick(-1);
        push_tick(32767);
        push_tick(0);
        push_tick(9000);
        push_tick(9000);
        drain();
        // writes to unused indexes must leave the counters alone
        push_tick(-1);
        push_tick(12000);
        drain();
        cfg_write(CFG_SPARE_LO, 1);
        cfg_write(CFG_SPARE_HI, 262143);
        repeat (4) push_tick(12000);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_player(1, 131071, -131072, 2, 1);
                1: set_player(5, -131072, 131071, 3, 2);
                2: set_player(8, rand_amp(), rand_amp(), 4, 3);
                3: set_player(3, 16384, 1000, 65535, 0);
                4: set_player(16, rand_amp(), rand_amp(), 0, 65535);
                5: set_player(0, rand_amp(), rand_amp(), 2, 2);
                default: set_player($urandom_range(32, 1), rand_amp(), rand_amp(),
                                    $urandom_range(5, 1), $urandom_range(4, 1));
            endcase
            len = reg_len;
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            if (ph == 0) rx_hold_go = 1'b1;
            gen_traffic(len, BURST_WORDS);
            drain();
        end

        // full-depth passes, then a length past the depth
        tx_idle_pct = 11;
        rx_stall_pct = 11;
        dummy = 0;
        set_player(WAVE_DEPTH, 16384, -8192, 2, 1);
        play_burst(WAVE_DEPTH, dummy);
        drain();
        set_player(8191, -131072, 131071, 65535, 65535);
        play_burst(WAVE_DEPTH, dummy);
        drain();

        $display("summary: %0d words accepted, %0d samples checked (%0d from the waveform)",
                 n_in, n_checked, n_playing);
        $display("summary: zero, short, random, full and past-depth lengths, %0d cycles",
                 cycles);
        if (n_err == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
